### hw/rtl/partitioned_task_mailbox_defines.svh
// Assertion macros shared by the mailbox checker.
`ifndef PARTITIONED_TASK_MAILBOX_DEFINES_SVH
`define PARTITIONED_TASK_MAILBOX_DEFINES_SVH

// Check sampled on clk, switched off while reset is asserted.
`define PTM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check sampled on clk that also holds while reset is asserted.
`define PTM_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/ptm_pkg.sv
// Shared constants, tables and types of the partitioned task mailbox.
`timescale 1ns / 1ps

package ptm_pkg;

	localparam int TOTAL_SLOTS = 64;
	localparam int MAX_TASKS   = 15;
	localparam int SLOT_W      = $clog2(TOTAL_SLOTS);
	localparam int CNT_W       = SLOT_W + 1;
	localparam int TASK_W      = 4;
	localparam int CODE_W      = 16;
	localparam int DATA_W      = 16;
	localparam int BYTE_W      = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// Partition size for each task count (task count + 1 partitions).
	localparam logic [CNT_W-1:0] PART_SIZE [2**TASK_W] = '{
		CNT_W'(TOTAL_SLOTS / 1),  CNT_W'(TOTAL_SLOTS / 2),
		CNT_W'(TOTAL_SLOTS / 3),  CNT_W'(TOTAL_SLOTS / 4),
		CNT_W'(TOTAL_SLOTS / 5),  CNT_W'(TOTAL_SLOTS / 6),
		CNT_W'(TOTAL_SLOTS / 7),  CNT_W'(TOTAL_SLOTS / 8),
		CNT_W'(TOTAL_SLOTS / 9),  CNT_W'(TOTAL_SLOTS / 10),
		CNT_W'(TOTAL_SLOTS / 11), CNT_W'(TOTAL_SLOTS / 12),
		CNT_W'(TOTAL_SLOTS / 13), CNT_W'(TOTAL_SLOTS / 14),
		CNT_W'(TOTAL_SLOTS / 15), CNT_W'(TOTAL_SLOTS / 16)
	};

	localparam logic [TASK_W-1:0] TASKS_RESET    = TASK_W'(1);
	localparam logic [CODE_W-1:0] WILDCARD_RESET = '1;
	localparam logic [BYTE_W-1:0] DEF_TYPE_RESET = '0;
	localparam logic [CODE_W-1:0] NONE_CODE      = '1;
	localparam logic [DATA_W-1:0] NONE_DATA      = '1;
	localparam logic [BYTE_W-1:0] NONE_BYTE      = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_TASKS    = 2'd0,
		CFG_WILDCARD     = 2'd1,
		CFG_DEFAULT_TYPE = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		REQ_SEND = 1'b0,
		REQ_GET  = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [DATA_W-1:0] data;
		logic [BYTE_W-1:0] source;
		logic [TASK_W-1:0] dest;
		logic [BYTE_W-1:0] mtype;
	} msg_t;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic done;
	} dp_sts_t;

endpackage

### hw/rtl/ptm_ctrl.sv
// Controller of the mailbox: request intake, slot scan sequencing, result handoff.
`timescale 1ns / 1ps

module ptm_ctrl import ptm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  dp_sts_t   sts,
	output ctrl_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd.load   = req_valid && (state_q == ST_IDLE);
		cmd.step   = (state_q == ST_SCAN) && !sts.done;
		// a finished scan waits here while the result register is still full
		cmd.commit = (state_q == ST_SCAN) && sts.done && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cmd.commit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.commit) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

endmodule

### hw/rtl/ptm_dp.sv
// Datapath of the mailbox: config registers, slot memory, valid bits, scan and result word.
`timescale 1ns / 1ps

module ptm_dp import ptm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	output dp_sts_t               sts,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_type,
	input  logic [TASK_W-1:0]     task_id,
	input  logic [CODE_W-1:0]     message_code,
	input  logic [DATA_W-1:0]     message_data,
	input  logic [BYTE_W-1:0]     source_id,
	input  logic [BYTE_W-1:0]     message_type,
	output logic                  success,
	output logic [CODE_W-1:0]     out_code,
	output logic [DATA_W-1:0]     out_data,
	output logic [BYTE_W-1:0]     out_source,
	output logic [BYTE_W-1:0]     out_destination,
	output logic [BYTE_W-1:0]     out_type
);

	localparam int PROD_W = TASK_W + CNT_W;

	// configuration
	logic [TASK_W-1:0] num_tasks_q;
	logic [CODE_W-1:0] wildcard_q;
	logic [BYTE_W-1:0] def_type_q;

	// request held for the scan
	logic              req_get_q;
	logic [TASK_W-1:0] req_task_q;
	logic [CODE_W-1:0] req_code_q;
	logic [DATA_W-1:0] req_data_q;
	logic [BYTE_W-1:0] req_src_q;
	logic [BYTE_W-1:0] req_mtype_q;
	logic              in_range_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  end_q;

	// check stage
	logic              chk_v_s1;
	logic [SLOT_W-1:0] chk_idx_s1;
	msg_t              rd_data_s1;

	// store
	msg_t                   mem [TOTAL_SLOTS];
	logic [TOTAL_SLOTS-1:0] valid_q;

	// result word
	logic              success_q;
	logic [CODE_W-1:0] out_code_q;
	logic [DATA_W-1:0] out_data_q;
	logic [BYTE_W-1:0] out_source_q;
	logic [BYTE_W-1:0] out_dest_q;
	logic [BYTE_W-1:0] out_type_q;

	logic [CNT_W-1:0]  part;
	logic [PROD_W-1:0] base_full;
	logic [CNT_W-1:0]  base;
	logic [CNT_W-1:0]  first;
	logic [CNT_W-1:0]  end_c;
	logic              issue_ok;
	logic              slot_valid;
	logic              match;
	logic              hit;
	logic              write_slot;
	msg_t              wr_msg;

	// partition bounds of the addressed mailbox; the scheduler's runs to the end
	assign part      = PART_SIZE[num_tasks_q];
	assign base_full = PROD_W'(task_id) * PROD_W'(part);
	assign base      = base_full[CNT_W-1:0];
	assign first     = base + CNT_W'(1);
	assign end_c     = (task_id == num_tasks_q) ? CNT_W'(TOTAL_SLOTS) : base + part;

	assign issue_ok   = in_range_q && (idx_q < end_q);
	assign slot_valid = valid_q[chk_idx_s1];
	assign match      = slot_valid &&
		((rd_data_s1.code == req_code_q) || (req_code_q == wildcard_q));
	assign hit        = chk_v_s1 && ((req_get_q == REQ_GET) ? match : !slot_valid);
	assign sts.done   = hit || (!chk_v_s1 && !issue_ok);

	assign write_slot  = cmd.commit && hit && (req_get_q == REQ_SEND);
	assign wr_msg.code   = req_code_q;
	assign wr_msg.data   = req_data_q;
	assign wr_msg.source = req_src_q;
	assign wr_msg.dest   = req_task_q;
	assign wr_msg.mtype  = req_mtype_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_tasks_q <= TASKS_RESET;
			wildcard_q  <= WILDCARD_RESET;
			def_type_q  <= DEF_TYPE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUM_TASKS:    num_tasks_q <= cfg_data[TASK_W-1:0];
				CFG_WILDCARD:     wildcard_q  <= cfg_data[CODE_W-1:0];
				CFG_DEFAULT_TYPE: def_type_q  <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// a new partitioning empties every mailbox
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cfg_we && (cfg_index == CFG_NUM_TASKS)) begin
			valid_q <= '0;
		end else if (cmd.commit && hit) begin
			valid_q[chk_idx_s1] <= (req_get_q == REQ_SEND);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_v_s1 <= 1'b0;
		end else if (cmd.load) begin
			chk_v_s1 <= 1'b0;
		end else if (cmd.step) begin
			chk_v_s1 <= issue_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_get_q   <= req_type;
			req_task_q  <= task_id;
			req_code_q  <= message_code;
			req_data_q  <= message_data;
			req_src_q   <= source_id;
			req_mtype_q <= message_type;
			in_range_q  <= (task_id <= num_tasks_q);
			idx_q       <= first;
			end_q       <= end_c;
		end else if (cmd.step) begin
			idx_q <= idx_q + CNT_W'(1);
		end
		if (cmd.step) begin
			chk_idx_s1 <= idx_q[SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) rd_data_s1 <= mem[idx_q[SLOT_W-1:0]];
		if (write_slot) mem[chk_idx_s1] <= wr_msg;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			success_q <= hit;
			if (hit && (req_get_q == REQ_GET)) begin
				out_code_q   <= rd_data_s1.code;
				out_data_q   <= rd_data_s1.data;
				out_source_q <= rd_data_s1.source;
				out_dest_q   <= BYTE_W'(rd_data_s1.dest);
				out_type_q   <= rd_data_s1.mtype;
			end else begin
				out_code_q   <= NONE_CODE;
				out_data_q   <= NONE_DATA;
				out_source_q <= NONE_BYTE;
				out_dest_q   <= NONE_BYTE;
				out_type_q   <= def_type_q;
			end
		end
	end

	assign success         = success_q;
	assign out_code        = out_code_q;
	assign out_data        = out_data_q;
	assign out_source      = out_source_q;
	assign out_destination = out_dest_q;
	assign out_type        = out_type_q;

endmodule

### hw/rtl/partitioned_task_mailbox.sv
// Partitioned task mailbox: top level joining controller and datapath.
//
// A request scans the addressed partition of P slots from its second slot on, where P is
// 64 / (number_of_tasks + 1) slots, the scheduler's partition also taking the
// remainder at the end of the store; a send or get ends its scan at its first hit, and
// a task index above number_of_tasks gets no scan. The scan reads one slot per cycle from the
// single-port slot memory. One request is in flight at a time; a new one is taken as soon as
// the previous result is in the output register, even if it has not been taken yet. Writing
// register 0 empties all mailboxes at once; the configuration port is always ready and must
// only be used while no request is in flight.
`timescale 1ns / 1ps

module partitioned_task_mailbox import ptm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic                  req_type,
	input  logic [TASK_W-1:0]     task_id,
	input  logic [CODE_W-1:0]     message_code,
	input  logic [DATA_W-1:0]     message_data,
	input  logic [BYTE_W-1:0]     source_id,
	input  logic [BYTE_W-1:0]     message_type,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic                  success,
	output logic [CODE_W-1:0]     out_code,
	output logic [DATA_W-1:0]     out_data,
	output logic [BYTE_W-1:0]     out_source,
	output logic [BYTE_W-1:0]     out_destination,
	output logic [BYTE_W-1:0]     out_type
);

	ctrl_cmd_t cmd;
	dp_sts_t   sts;
	logic      cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	ptm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ptm_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.req_type        (req_type),
		.task_id         (task_id),
		.message_code    (message_code),
		.message_data    (message_data),
		.source_id       (source_id),
		.message_type    (message_type),
		.success         (success),
		.out_code        (out_code),
		.out_data        (out_data),
		.out_source      (out_source),
		.out_destination (out_destination),
		.out_type        (out_type)
	);

endmodule

### hw/rtl/ptm_checker.sv
// Port-level checks of the partitioned task mailbox, bound to the top level.
`timescale 1ns / 1ps
`include "partitioned_task_mailbox_defines.svh"

module ptm_checker import ptm_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  req_type,
	input logic [TASK_W-1:0]     task_id,
	input logic [CODE_W-1:0]     message_code,
	input logic [DATA_W-1:0]     message_data,
	input logic [BYTE_W-1:0]     source_id,
	input logic [BYTE_W-1:0]     message_type,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic                  success,
	input logic [CODE_W-1:0]     out_code,
	input logic [DATA_W-1:0]     out_data,
	input logic [BYTE_W-1:0]     out_source,
	input logic [BYTE_W-1:0]     out_destination,
	input logic [BYTE_W-1:0]     out_type
);

	// no word is offered while reset is held
	`PTM_ASSERT_RST(a_no_rsp_in_reset, !arst_n |-> !rsp_valid, "result word offered during reset")

	`PTM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_code) && $stable(out_data) && $stable(success), "stalled result word changed")

	// a failed request always carries the default message fields
	`PTM_ASSERT(a_miss_default, rsp_valid && !success |-> out_code == NONE_CODE && out_data == NONE_DATA && out_source == NONE_BYTE && out_destination == NONE_BYTE, "failed request without default message")

	// a returned destination is a mailbox index or the default marker
	`PTM_ASSERT(a_dest_range, rsp_valid |-> out_destination == NONE_BYTE || out_destination[BYTE_W-1:TASK_W] == '0, "destination outside mailbox range")

endmodule

bind partitioned_task_mailbox ptm_checker u_ptm_checker (.*);
